/* design/hrlp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hrlp_pkg;

	// Result kinds as they appear on the result channel.
	localparam logic [1:0] KIND_PATH   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// Method codes.
	localparam logic [2:0] METHOD_GET    = 3'd0;
	localparam logic [2:0] METHOD_POST   = 3'd1;
	localparam logic [2:0] METHOD_HEAD   = 3'd2;
	localparam logic [2:0] METHOD_PUT    = 3'd3;
	localparam logic [2:0] METHOD_DELETE = 3'd4;

	localparam int METHOD_COUNT = 5;

	// Field widths of the result item.
	localparam int LEN_W = 13;

	// Characters with a special role in the line.
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// Version token, one byte per position.
	localparam logic [7:0] VERSION_TOKEN [8] = '{
		8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30
	};
	localparam logic [3:0] VERSION_LEN = 4'd8;

	// Method words, padded with zeros to eight positions.
	localparam logic [7:0] METHOD_WORDS [METHOD_COUNT][8] = '{
		'{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00}
	};
	localparam logic [3:0] METHOD_LENGTHS [METHOD_COUNT] = '{
		4'd3, 4'd4, 4'd4, 4'd3, 4'd6
	};

	// Parser phase, one-hot.
	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_VERSION = 4'b0010,
		PH_METHOD  = 4'b0100,
		PH_PATH    = 4'b1000
	} phase_t;

	// One classified result on its way from the front to the back.
	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [2:0]       method;
		logic [LEN_W-1:0] length;
	} res_t;

	// Handshake between the queue and the back part.
	typedef struct packed {
		logic valid;
		res_t entry;
	} queue_out_t;

endpackage

`default_nettype wire

/* design/hrlp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrlp_front #(
	parameter int MAX_LINE_BYTES = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    data_byte,
	input  wire logic          starts_buffer,
	input  wire logic          ends_buffer,
	output logic               push,
	output hrlp_pkg::res_t     push_entry
);
	import hrlp_pkg::*;

	localparam int CNT_W = $clog2(MAX_LINE_BYTES + 1);
	localparam logic [CNT_W:0] MAX_COUNT = (CNT_W + 1)'(MAX_LINE_BYTES);

	phase_t                    phase_q;
	logic [3:0]                pos_q;
	logic [METHOD_COUNT-1:0]   cand_q;
	logic [CNT_W-1:0]          count_q;
	logic [2:0]                chosen_q;

	phase_t                    phase_e, phase_n;
	logic [3:0]                pos_e, pos_n;
	logic [METHOD_COUNT-1:0]   cand_e, cand_n;
	logic [CNT_W-1:0]          count_e, count_n;
	logic [2:0]                chosen_e, chosen_n;
	logic [CNT_W:0]            count_inc;
	logic [CNT_W+LEN_W-1:0]    count_ext;
	logic [METHOD_COUNT-1:0]   len_match;
	logic [METHOD_COUNT-1:0]   char_match;
	logic                      emit;
	logic [1:0]                kind;
	logic [7:0]                pbyte;

	// A first mark restarts the parse before the byte is looked at.
	always_comb begin
		if (starts_buffer) begin
			phase_e  = PH_VERSION;
			pos_e    = '0;
			cand_e   = '1;
			count_e  = '0;
			chosen_e = METHOD_GET;
		end else begin
			phase_e  = phase_q;
			pos_e    = pos_q;
			cand_e   = cand_q;
			count_e  = count_q;
			chosen_e = chosen_q;
		end
	end

	assign count_inc = {1'b0, count_e} + (CNT_W + 1)'(1);
	assign count_ext = {{LEN_W{1'b0}}, count_inc[CNT_W-1:0]};

	// Per-method compare of the current word position.
	always_comb begin
		for (int i = 0; i < METHOD_COUNT; i++) begin
			len_match[i]  = cand_e[i] && (METHOD_LENGTHS[i] == pos_e);
			char_match[i] = cand_e[i] && (pos_e < METHOD_LENGTHS[i]) &&
				(METHOD_WORDS[i][pos_e[2:0]] == data_byte);
		end
	end

	// Classify the byte and work out the next parse state.
	always_comb begin
		phase_n  = phase_e;
		pos_n    = pos_e;
		cand_n   = cand_e;
		count_n  = count_e;
		chosen_n = chosen_e;
		emit     = 1'b0;
		kind     = KIND_REJECT;
		pbyte    = '0;
		if (phase_e != PH_IDLE) begin
			emit = 1'b1;
			if (count_inc > MAX_COUNT) begin
				phase_n = PH_IDLE;
			end else begin
				count_n = count_inc[CNT_W-1:0];
				case (phase_e)
					PH_VERSION: begin
						if (pos_e < VERSION_LEN) begin
							if (data_byte != VERSION_TOKEN[pos_e[2:0]]) begin
								phase_n = PH_IDLE;
							end else begin
								pos_n = pos_e + 4'd1;
								emit  = ends_buffer;
								if (ends_buffer) phase_n = PH_IDLE;
							end
						end else if (data_byte != CHAR_SPACE) begin
							phase_n = PH_IDLE;
						end else begin
							phase_n = ends_buffer ? PH_IDLE : PH_METHOD;
							pos_n   = '0;
							cand_n  = '1;
							emit    = ends_buffer;
						end
					end
					PH_METHOD: begin
						if (data_byte == CHAR_SPACE) begin
							if (len_match == '0) begin
								phase_n = PH_IDLE;
							end else begin
								// Lowest matching method wins.
								for (int i = METHOD_COUNT - 1; i >= 0; i--) begin
									if (len_match[i]) chosen_n = 3'(i);
								end
								phase_n = ends_buffer ? PH_IDLE : PH_PATH;
								pos_n   = '0;
								emit    = ends_buffer;
							end
						end else begin
							cand_n = char_match;
							if (char_match == '0) begin
								phase_n = PH_IDLE;
							end else begin
								pos_n = pos_e + 4'd1;
								emit  = ends_buffer;
								if (ends_buffer) phase_n = PH_IDLE;
							end
						end
					end
					PH_PATH: begin
						if (data_byte == CHAR_NEWLINE) begin
							phase_n = PH_IDLE;
							kind    = KIND_ACCEPT;
						end else if (ends_buffer) begin
							phase_n = PH_IDLE;
						end else begin
							kind  = KIND_PATH;
							pbyte = data_byte;
						end
					end
					default: begin
						phase_n = PH_IDLE;
						emit    = 1'b0;
					end
				endcase
			end
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			cand_q   <= '1;
			count_q  <= '0;
			chosen_q <= METHOD_GET;
		end else if (accept) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			cand_q   <= cand_n;
			count_q  <= count_n;
			chosen_q <= chosen_n;
		end
	end

	// Every result item goes to the queue with unused fields cleared.
	always_comb begin
		push              = accept && emit;
		push_entry.kind   = kind;
		push_entry.data   = pbyte;
		push_entry.method = (kind == KIND_ACCEPT) ? chosen_e : METHOD_GET;
		push_entry.length = (kind == KIND_ACCEPT) ? count_ext[LEN_W-1:0] : '0;
	end

endmodule

`default_nettype wire

/* design/hrlp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrlp_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire hrlp_pkg::res_t    push_entry,
	output logic                   full,
	input  wire logic              pop,
	output hrlp_pkg::queue_out_t   head
);
	import hrlp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	res_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (fill_q == FULL_CNT);
	assign do_push    = push && !full;
	assign do_pop     = pop && (fill_q != '0);
	assign head.valid = (fill_q != '0);
	assign head.entry = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)      fill_q <= fill_q + CNT_W'(1);
			else if (do_pop && !do_push) fill_q <= fill_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

/* design/hrlp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrlp_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire hrlp_pkg::queue_out_t      head,
	output logic                           pop,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output logic [1:0]                     result_kind,
	output logic [7:0]                     path_byte,
	output logic [2:0]                     method_code,
	output logic [hrlp_pkg::LEN_W-1:0]     consumed_length
);
	import hrlp_pkg::*;

	logic valid_q;
	res_t out_q;

	// The output register takes a new entry when it is empty or being drained.
	assign pop = head.valid && (!valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result_ready) begin
			valid_q <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_q <= head.entry;
	end

	assign result_valid    = valid_q;
	assign result_kind     = out_q.kind;
	assign path_byte       = out_q.data;
	assign method_code     = out_q.method;
	assign consumed_length = out_q.length;

endmodule

`default_nettype wire

/* design/http_request_line_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// data      in         data_valid / data_ready     data_byte, starts_buffer, ends_buffer
// result    out        result_valid / result_ready result_kind, path_byte, method_code,
//                                                  consumed_length
//
// One byte is taken per cycle while the queue is not full. A result passes
// from its byte's transfer through the result queue and then the output
// register before its own transfer. The byte rate is set by the parse step
// and by the result queue between the parser and the output register.
// data_ready drops only while the queue is full, so a stalled result side
// stops the input after QUEUE_DEPTH + 1 results. Reset empties the queue and
// the output register and puts the parser in its idle phase.

module http_request_line_parser #(
	parameter int MAX_LINE_BYTES = 4096,
	parameter int QUEUE_DEPTH    = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      data_valid,
	output logic                           data_ready,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      starts_buffer,
	input  wire logic                      ends_buffer,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output logic [1:0]                     result_kind,
	output logic [7:0]                     path_byte,
	output logic [2:0]                     method_code,
	output logic [hrlp_pkg::LEN_W-1:0]     consumed_length
);
	import hrlp_pkg::*;

	logic       accept;
	logic       push;
	res_t       push_entry;
	logic       full;
	logic       pop;
	queue_out_t head;

	assign data_ready = !full;
	assign accept     = data_valid && data_ready;

	// Front: parse and classify each byte.
	hrlp_front #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.starts_buffer(starts_buffer),
		.ends_buffer  (ends_buffer),
		.push         (push),
		.push_entry   (push_entry)
	);

	// Queue between the two sides.
	hrlp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.head      (head)
	);

	// Back: output register toward the result channel.
	hrlp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result_kind    (result_kind),
		.path_byte      (path_byte),
		.method_code    (method_code),
		.consumed_length(consumed_length)
	);

endmodule

`default_nettype wire

/* design/hrlp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrlp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [1:0]  result_kind,
	input wire logic [7:0]  path_byte,
	input wire logic [2:0]  method_code,
	input wire logic [12:0] consumed_length
);
	import hrlp_pkg::*;

	// A stalled result keeps its place and its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid &&
		$stable({result_kind, path_byte, method_code, consumed_length}))
		else $error("result changed while stalled");

	// Only the three defined kinds leave the block.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_kind == KIND_PATH || result_kind == KIND_ACCEPT ||
		result_kind == KIND_REJECT))
		else $error("undefined result kind");

	// The path byte is cleared for every verdict.
	a_path_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_PATH |-> path_byte == 8'd0)
		else $error("path byte set on a verdict");

	// Method and length are set only on an accepted line.
	a_accept_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_ACCEPT |->
		method_code == METHOD_GET && consumed_length == 13'd0)
		else $error("method or length set outside an accepted line");

	// An accepted line names a known method and has a nonzero length.
	a_accept_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_ACCEPT |->
		method_code <= METHOD_DELETE && consumed_length != 13'd0)
		else $error("accepted line with bad method or length");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.result_kind    (result_kind),
	.path_byte      (path_byte),
	.method_code    (method_code),
	.consumed_length(consumed_length)
);

`default_nettype wire
